### rtl/pkm_pkg.sv
// Shared types, constants and helper functions for the pixel k-space mapper.
package pkm_pkg;

  localparam int FRONT_STAGES = 9;
  localparam int SQ_STEPS     = 32;
  localparam int DIV_STEPS    = 32;
  localparam int LATENCY      = FRONT_STAGES + SQ_STEPS + 1 + DIV_STEPS + 2
                                + SQ_STEPS + DIV_STEPS + 1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_POS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_OUTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_INNER  = 3'd5;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic signed [65:0] Z_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] Z_MIN = 66'sh3_8000_0000_0000_0000;

  typedef struct packed {
    logic [19:0]        pitch;
    logic signed [31:0] stage_pos;
    logic [31:0]        stage_scale;
    logic [23:0]        wavelength;
    logic [23:0]        mask_outer;
    logic [23:0]        mask_inner;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pitch:       20'd110000,
    stage_pos:   32'sd0,
    stage_scale: 32'd1000000,
    wavelength:  24'd65536,
    mask_outer:  24'hFF_FFFF,
    mask_inner:  24'd0
  };

  typedef struct packed {
    logic nx;
    logic ny;
    logic nz;
    logic satz;
    logic mask;
    logic last;
  } tag_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] y;
    logic [29:0] z;
    logic [60:0] sum_xy;
    logic [61:0] sum_xyz;
    tag_t        tag;
  } front_t;

  // pixel position times pitch, Q.8 rounded half away from zero, magnitude only
  function automatic logic [36:0] round_nm(input logic signed [44:0] p);
    logic [44:0] mag;
    logic [44:0] rnd;
    mag = p[44] ? 45'(-p) : 45'(p);
    rnd = (mag + 45'd128) >> 8;
    return rnd[36:0];
  endfunction

  // signed clip of a quotient magnitude: {clipped, value}
  function automatic logic [32:0] sclip(input logic [31:0] q, input logic ovf,
                                        input logic neg);
    logic [32:0] res;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) res = {1'b1, 32'h8000_0000};
      else res = {1'b0, 32'(~q + 32'd1)};
    end else begin
      if (ovf || q[31]) res = {1'b1, 32'h7FFF_FFFF};
      else res = {1'b0, q};
    end
    return res;
  endfunction

endpackage

### rtl/pkm_front.sv
// Front pipeline: scale to nm, add detector distance, block-normalize, square and sum.
module pkm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic signed [23:0]  pos_z,
  input  logic [23:0]         radius_px,
  input  logic                last_pixel,
  input  pkm_pkg::cfg_t       cfg,
  output logic                out_vld,
  output pkm_pkg::front_t     out
);

  logic [pkm_pkg::FRONT_STAGES-1:0] vld;

  logic signed [44:0] px_c, py_c, pz_c;
  logic signed [64:0] zs_c;

  logic signed [44:0] px1, py1, pz1;
  logic signed [64:0] zs1;
  pkm_pkg::tag_t      t1;

  logic [36:0]        ax_c, ay_c, zp_m;
  logic [36:0]        ax2, ay2;
  logic signed [37:0] zp2;
  logic signed [64:0] zs2;
  pkm_pkg::tag_t      t2;

  logic signed [65:0] zsum_c;
  logic signed [63:0] z3_c;
  logic               satz_c;
  logic [36:0]        ax3, ay3;
  logic signed [63:0] z3;
  pkm_pkg::tag_t      t3;

  logic [36:0]        ax4, ay4, mxy4;
  logic [63:0]        az4;
  pkm_pkg::tag_t      t4;

  logic [63:0]        ax5, ay5, az5, m5;
  pkm_pkg::tag_t      t5;

  logic [6:0]         blen_c;
  logic [5:0]         sh_c;
  logic [63:0]        ax6, ay6, az6;
  logic [5:0]         sh6;
  pkm_pkg::tag_t      t6;

  logic [63:0]        xs_c, ys_c, zs7_c;
  logic [29:0]        x7, y7, z7;
  pkm_pkg::tag_t      t7;

  logic [59:0]        xx8, yy8, zz8;
  logic [29:0]        x8, y8, z8;
  pkm_pkg::tag_t      t8;

  logic [60:0]        sxy9;
  logic [61:0]        sxyz9;
  logic [29:0]        x9, y9, z9;
  pkm_pkg::tag_t      t9;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[pkm_pkg::FRONT_STAGES-2:0], in_vld};
    end
  end

  assign px_c = pos_x * $signed({1'b0, cfg.pitch});
  assign py_c = pos_y * $signed({1'b0, cfg.pitch});
  assign pz_c = pos_z * $signed({1'b0, cfg.pitch});
  assign zs_c = cfg.stage_pos * $signed({1'b0, cfg.stage_scale});

  always_ff @(posedge clk) begin
    px1 <= px_c;
    py1 <= py_c;
    pz1 <= pz_c;
    zs1 <= zs_c;
    t1  <= '{nx: 1'b0, ny: 1'b0, nz: 1'b0, satz: 1'b0,
             mask: (radius_px > cfg.mask_inner) && (radius_px < cfg.mask_outer),
             last: last_pixel};
  end

  assign ax_c = pkm_pkg::round_nm(px1);
  assign ay_c = pkm_pkg::round_nm(py1);
  assign zp_m = pkm_pkg::round_nm(pz1);

  always_ff @(posedge clk) begin
    ax2 <= ax_c;
    ay2 <= ay_c;
    zp2 <= pz1[44] ? -$signed({1'b0, zp_m}) : $signed({1'b0, zp_m});
    zs2 <= zs1;
    t2  <= '{nx: px1[44] && (ax_c != '0), ny: py1[44] && (ay_c != '0),
             nz: t1.nz, satz: t1.satz, mask: t1.mask, last: t1.last};
  end

  assign zsum_c = 66'(zs2) + 66'(zp2);

  // clip the distance sum to the signed 64-bit range
  always_comb begin
    if (zsum_c > pkm_pkg::Z_MAX) begin
      z3_c   = 64'sh7FFF_FFFF_FFFF_FFFF;
      satz_c = 1'b1;
    end else if (zsum_c < pkm_pkg::Z_MIN) begin
      z3_c   = 64'sh8000_0000_0000_0000;
      satz_c = 1'b1;
    end else begin
      z3_c   = zsum_c[63:0];
      satz_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ax3 <= ax2;
    ay3 <= ay2;
    z3  <= z3_c;
    t3  <= '{nx: t2.nx, ny: t2.ny, nz: t2.nz, satz: t2.satz | satz_c,
             mask: t2.mask, last: t2.last};
  end

  always_ff @(posedge clk) begin
    ax4  <= ax3;
    ay4  <= ay3;
    az4  <= z3[63] ? 64'(-z3) : 64'(z3);
    mxy4 <= (ax3 > ay3) ? ax3 : ay3;
    t4   <= '{nx: t3.nx, ny: t3.ny, nz: z3[63], satz: t3.satz,
              mask: t3.mask, last: t3.last};
  end

  always_ff @(posedge clk) begin
    ax5 <= 64'(ax4);
    ay5 <= 64'(ay4);
    az5 <= az4;
    m5  <= (az4 > 64'(mxy4)) ? az4 : 64'(mxy4);
    t5  <= t4;
  end

  // shift that brings the largest magnitude below 2^30
  always_comb begin
    blen_c = '0;
    for (int i = 0; i < 64; i++) begin
      if (m5[i]) blen_c = 7'(i + 1);
    end
    sh_c = (blen_c > 7'd30) ? 6'(blen_c - 7'd30) : 6'd0;
  end

  always_ff @(posedge clk) begin
    ax6 <= ax5;
    ay6 <= ay5;
    az6 <= az5;
    sh6 <= sh_c;
    t6  <= t5;
  end

  assign xs_c  = ax6 >> sh6;
  assign ys_c  = ay6 >> sh6;
  assign zs7_c = az6 >> sh6;

  always_ff @(posedge clk) begin
    x7 <= xs_c[29:0];
    y7 <= ys_c[29:0];
    z7 <= zs7_c[29:0];
    t7 <= t6;
  end

  always_ff @(posedge clk) begin
    xx8 <= x7 * x7;
    yy8 <= y7 * y7;
    zz8 <= z7 * z7;
    x8  <= x7;
    y8  <= y7;
    z8  <= z7;
    t8  <= t7;
  end

  always_ff @(posedge clk) begin
    sxy9  <= 61'(xx8) + 61'(yy8);
    sxyz9 <= 62'(xx8) + 62'(yy8) + 62'(zz8);
    x9    <= x8;
    y9    <= y8;
    z9    <= z8;
    t9    <= t8;
  end

  assign out_vld     = vld[pkm_pkg::FRONT_STAGES-1];
  assign out.x       = x9;
  assign out.y       = y9;
  assign out.z       = z9;
  assign out.sum_xy  = sxy9;
  assign out.sum_xyz = sxyz9;
  assign out.tag     = t9;

endmodule

### rtl/pkm_sqrt.sv
// Pipelined integer square root: 64-bit radicand, one result bit per stage.
module pkm_sqrt (
  input  logic        clk,
  input  logic [63:0] din,
  output logic [31:0] dout
);

  logic [33:0] rem_q  [pkm_pkg::SQ_STEPS];
  logic [31:0] root_q [pkm_pkg::SQ_STEPS];
  logic [63:0] rest_q [pkm_pkg::SQ_STEPS];

  for (genvar i = 0; i < pkm_pkg::SQ_STEPS; i++) begin : g_step
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rest_in;
    logic [35:0] cur;
    logic [35:0] trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = din;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rest_in = rest_q[i-1];
    end

    assign cur   = {rem_in, rest_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      rest_q[i] <= {rest_in[61:0], 2'b00};
      if (cur >= trial) begin
        rem_q[i]  <= 34'(cur - trial);
        root_q[i] <= {root_in[30:0], 1'b1};
      end else begin
        rem_q[i]  <= cur[33:0];
        root_q[i] <= {root_in[30:0], 1'b0};
      end
    end
  end

  assign dout = root_q[pkm_pkg::SQ_STEPS-1];

endmodule

### rtl/pkm_div.sv
// Pipelined restoring divider: 64-bit by 32-bit, 32-bit quotient with overflow flag.
module pkm_div (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo,
  output logic        ovf
);

  logic [31:0] rem_q [pkm_pkg::DIV_STEPS];
  logic [31:0] low_q [pkm_pkg::DIV_STEPS];
  logic [31:0] den_q [pkm_pkg::DIV_STEPS];
  logic        ovf_q [pkm_pkg::DIV_STEPS];

  for (genvar i = 0; i < pkm_pkg::DIV_STEPS; i++) begin : g_step
    logic [31:0] rem_in;
    logic [31:0] low_in;
    logic [31:0] den_in;
    logic        ovf_in;
    logic [32:0] t;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in = num[63:32];
      assign low_in = num[31:0];
      assign den_in = den;
      // quotient would not fit in 32 bits (also catches a zero divisor)
      assign ovf_in = num[63:32] >= den;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign den_in = den_q[i-1];
      assign ovf_in = ovf_q[i-1];
    end

    assign t  = {rem_in, low_in[31]};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_q[i] <= ge ? 32'(t - {1'b0, den_in}) : t[31:0];
      low_q[i] <= {low_in[30:0], ge};
      den_q[i] <= den_in;
      ovf_q[i] <= ovf_in;
    end
  end

  assign quo = low_q[pkm_pkg::DIV_STEPS-1];
  assign ovf = ovf_q[pkm_pkg::DIV_STEPS-1];

endmodule

### rtl/pixel_kspace_mapper_top.sv
// Throughput: one pixel per cycle; every unit (three square roots, two divider
// banks, multipliers) is fully pipelined, one quotient or root bit per stage.
// Reset: synchronous; clears all valid bits and loads the register defaults.
// busy is high only during reset; results are strobed once and never held.
module pixel_kspace_mapper_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic signed [23:0]  pos_z,
  input  logic [23:0]         radius_px,
  input  logic                last_pixel,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                done,
  output logic signed [31:0]  k_x,
  output logic signed [31:0]  k_y,
  output logic signed [31:0]  k_z,
  output logic [31:0]         k_mag,
  output logic [31:0]         d_spacing,
  output logic                saturated,
  output logic                in_mask,
  output logic                last_out
);

  typedef struct packed {
    logic [29:0]   x;
    logic [29:0]   y;
    logic [29:0]   z;
    pkm_pkg::tag_t tag;
  } side1_t;

  typedef struct packed {
    pkm_pkg::tag_t tag;
    logic          rz;
    logic          rhoz;
  } side2_t;

  typedef struct packed {
    logic [30:0]   kx;
    logic [30:0]   ky;
    logic [31:0]   kz;
    logic [31:0]   d;
    logic          dovf;
    pkm_pkg::tag_t tag;
    logic          rz;
    logic          rhoz;
  } side3_t;

  typedef struct packed {
    logic [31:0]   d;
    logic          dovf;
    pkm_pkg::tag_t tag;
    logic          rz;
    logic          rhoz;
  } side4_t;

  pkm_pkg::cfg_t   cfg;
  logic [23:0]     wl;
  logic            f_vld;
  pkm_pkg::front_t f_out;

  logic [31:0] r_root, rho_root;
  side1_t      d1 [pkm_pkg::SQ_STEPS];
  logic [pkm_pkg::SQ_STEPS-1:0] v1;

  logic        p_vld;
  logic [63:0] p_numx, p_numy, p_numz, p_wr;
  logic [31:0] p_r, p_rho;
  side2_t      p_side;

  logic [31:0] qx, qy, qz, dq;
  logic        qx_o, qy_o, qz_o, dq_o;
  side2_t      d2 [pkm_pkg::DIV_STEPS];
  logic [pkm_pkg::DIV_STEPS-1:0] v2;

  logic [31:0] kz_c;
  logic        q_vld;
  logic [30:0] q_kx, q_ky;
  logic [31:0] q_kz;
  logic [61:0] q_kxx, q_kyy;
  logic [63:0] q_kzz;
  logic [31:0] q_d;
  logic        q_dovf;
  side2_t      q_side;

  logic        s_vld;
  logic [63:0] s_sum;
  side3_t      s_side;

  logic [31:0] root;
  side3_t      d3 [pkm_pkg::SQ_STEPS];
  logic [pkm_pkg::SQ_STEPS-1:0] v3;
  side3_t      t3;

  logic [31:0] kxq, kyq, kzq, kmq;
  logic        kxo, kyo, kzo, kmo;
  side4_t      d4 [pkm_pkg::DIV_STEPS];
  logic [pkm_pkg::DIV_STEPS-1:0] v4;
  side4_t      t4;

  logic [32:0] cx, cy, cz;
  logic [31:0] o_kx, o_ky, o_kz, o_kmag, o_d;
  logic        o_sat;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pkm_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pkm_pkg::REG_PITCH:       cfg.pitch       <= cfg_data[19:0];
        pkm_pkg::REG_STAGE_POS:   cfg.stage_pos   <= $signed(cfg_data);
        pkm_pkg::REG_STAGE_SCALE: cfg.stage_scale <= cfg_data;
        pkm_pkg::REG_WAVELENGTH:  cfg.wavelength  <= cfg_data[23:0];
        pkm_pkg::REG_MASK_OUTER:  cfg.mask_outer  <= cfg_data[23:0];
        pkm_pkg::REG_MASK_INNER:  cfg.mask_inner  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // a zero wavelength acts as the smallest step
  assign wl = (cfg.wavelength == '0) ? 24'd1 : cfg.wavelength;

  pkm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (start && !busy),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .radius_px  (radius_px),
    .last_pixel (last_pixel),
    .cfg        (cfg),
    .out_vld    (f_vld),
    .out        (f_out)
  );

  // r and rho
  pkm_sqrt u_sqrt_r   (.clk(clk), .din(64'(f_out.sum_xyz)), .dout(r_root));
  pkm_sqrt u_sqrt_rho (.clk(clk), .din(64'(f_out.sum_xy)),  .dout(rho_root));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
    end else begin
      v1 <= {v1[pkm_pkg::SQ_STEPS-2:0], f_vld};
    end
  end

  always_ff @(posedge clk) begin
    d1[0] <= '{x: f_out.x, y: f_out.y, z: f_out.z, tag: f_out.tag};
    for (int i = 1; i < pkm_pkg::SQ_STEPS; i++) begin
      d1[i] <= d1[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= v1[pkm_pkg::SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    p_numx      <= 64'({d1[pkm_pkg::SQ_STEPS-1].x, 30'b0});
    p_numy      <= 64'({d1[pkm_pkg::SQ_STEPS-1].y, 30'b0});
    p_numz      <= 64'({d1[pkm_pkg::SQ_STEPS-1].z, 30'b0});
    p_wr        <= 64'(wl) * 64'(r_root);
    p_r         <= r_root;
    p_rho       <= rho_root;
    p_side.tag  <= d1[pkm_pkg::SQ_STEPS-1].tag;
    p_side.rz   <= (r_root == '0);
    p_side.rhoz <= (rho_root == '0);
  end

  // unit ratios in Q.30 and the resolution
  pkm_div u_div_qx (.clk(clk), .num(p_numx), .den(p_r),   .quo(qx), .ovf(qx_o));
  pkm_div u_div_qy (.clk(clk), .num(p_numy), .den(p_r),   .quo(qy), .ovf(qy_o));
  pkm_div u_div_qz (.clk(clk), .num(p_numz), .den(p_r),   .quo(qz), .ovf(qz_o));
  pkm_div u_div_d  (.clk(clk), .num(p_wr),   .den(p_rho), .quo(dq), .ovf(dq_o));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= '0;
    end else begin
      v2 <= {v2[pkm_pkg::DIV_STEPS-2:0], p_vld};
    end
  end

  always_ff @(posedge clk) begin
    d2[0] <= p_side;
    for (int i = 1; i < pkm_pkg::DIV_STEPS; i++) begin
      d2[i] <= d2[i-1];
    end
  end

  // kz magnitude is 1 - z/r; a negative z adds
  assign kz_c = d2[pkm_pkg::DIV_STEPS-1].tag.nz ? pkm_pkg::ONE_Q30 + qz
                                                : pkm_pkg::ONE_Q30 - qz;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
      s_vld <= 1'b0;
    end else begin
      q_vld <= v2[pkm_pkg::DIV_STEPS-1];
      s_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    q_kx   <= qx[30:0];
    q_ky   <= qy[30:0];
    q_kz   <= kz_c;
    q_kxx  <= qx[30:0] * qx[30:0];
    q_kyy  <= qy[30:0] * qy[30:0];
    q_kzz  <= kz_c * kz_c;
    q_d    <= dq;
    q_dovf <= dq_o;
    q_side <= d2[pkm_pkg::DIV_STEPS-1];
  end

  always_ff @(posedge clk) begin
    s_sum       <= 64'(q_kxx) + 64'(q_kyy) + q_kzz;
    s_side.kx   <= q_kx;
    s_side.ky   <= q_ky;
    s_side.kz   <= q_kz;
    s_side.d    <= q_d;
    s_side.dovf <= q_dovf;
    s_side.tag  <= q_side.tag;
    s_side.rz   <= q_side.rz;
    s_side.rhoz <= q_side.rhoz;
  end

  pkm_sqrt u_sqrt_k (.clk(clk), .din(s_sum), .dout(root));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= '0;
    end else begin
      v3 <= {v3[pkm_pkg::SQ_STEPS-2:0], s_vld};
    end
  end

  always_ff @(posedge clk) begin
    d3[0] <= s_side;
    for (int i = 1; i < pkm_pkg::SQ_STEPS; i++) begin
      d3[i] <= d3[i-1];
    end
  end

  assign t3 = d3[pkm_pkg::SQ_STEPS-1];

  // divide by the wavelength
  pkm_div u_div_kx (.clk(clk), .num(64'({t3.kx, 10'b0})), .den(32'(wl)),
                    .quo(kxq), .ovf(kxo));
  pkm_div u_div_ky (.clk(clk), .num(64'({t3.ky, 10'b0})), .den(32'(wl)),
                    .quo(kyq), .ovf(kyo));
  pkm_div u_div_kz (.clk(clk), .num(64'({t3.kz, 10'b0})), .den(32'(wl)),
                    .quo(kzq), .ovf(kzo));
  pkm_div u_div_km (.clk(clk), .num(64'({root, 10'b0})),  .den(32'(wl)),
                    .quo(kmq), .ovf(kmo));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= '0;
    end else begin
      v4 <= {v4[pkm_pkg::DIV_STEPS-2:0], v3[pkm_pkg::SQ_STEPS-1]};
    end
  end

  always_ff @(posedge clk) begin
    d4[0] <= '{d: t3.d, dovf: t3.dovf, tag: t3.tag, rz: t3.rz, rhoz: t3.rhoz};
    for (int i = 1; i < pkm_pkg::DIV_STEPS; i++) begin
      d4[i] <= d4[i-1];
    end
  end

  assign t4 = d4[pkm_pkg::DIV_STEPS-1];

  always_comb begin
    cx     = pkm_pkg::sclip(kxq, kxo, t4.tag.nx);
    cy     = pkm_pkg::sclip(kyq, kyo, t4.tag.ny);
    cz     = pkm_pkg::sclip(kzq, kzo, 1'b1);
    o_kx   = cx[31:0];
    o_ky   = cy[31:0];
    o_kz   = cz[31:0];
    o_kmag = kmo ? 32'hFFFF_FFFF : kmq;
    o_sat  = t4.tag.satz | cx[32] | cy[32] | cz[32] | kmo;
    if (t4.rhoz || t4.dovf) begin
      o_d   = 32'hFFFF_FFFF;
      o_sat = 1'b1;
    end else begin
      o_d = t4.d;
    end
    // zero vector: drop the k results
    if (t4.rz) begin
      o_kx   = '0;
      o_ky   = '0;
      o_kz   = '0;
      o_kmag = '0;
      o_d    = 32'hFFFF_FFFF;
      o_sat  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4[pkm_pkg::DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    k_x       <= $signed(o_kx);
    k_y       <= $signed(o_ky);
    k_z       <= $signed(o_kz);
    k_mag     <= o_kmag;
    d_spacing <= o_d;
    saturated <= o_sat;
    in_mask   <= t4.tag.mask;
    last_out  <= t4.tag.last;
  end

endmodule

### rtl/pkm_checker.sv
// Port-level checker for the pixel k-space mapper, bound to the top level.
module pkm_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic signed [23:0]  pos_x,
  input logic signed [23:0]  pos_y,
  input logic signed [23:0]  pos_z,
  input logic [23:0]         radius_px,
  input logic                last_pixel,
  input logic                cfg_we,
  input logic [2:0]          cfg_index,
  input logic [31:0]         cfg_data,
  input logic                done,
  input logic signed [31:0]  k_x,
  input logic signed [31:0]  k_y,
  input logic signed [31:0]  k_z,
  input logic [31:0]         k_mag,
  input logic [31:0]         d_spacing,
  input logic                saturated,
  input logic                in_mask,
  input logic                last_out
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, pkm_pkg::LATENCY))
    else $error("done strobe does not follow request by fixed latency");

  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> last_out == $past(last_pixel, pkm_pkg::LATENCY))
    else $error("last_out does not match request");

  a_kz_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> (k_z == '0 || k_z[31]))
    else $error("k_z positive");

  a_kmag: assert property (@(posedge clk) disable iff (rst)
    (done && !saturated && k_mag == '0) |-> (k_x == '0 && k_y == '0))
    else $error("zero magnitude with nonzero transverse component");

endmodule

bind pixel_kspace_mapper_top pkm_checker u_pkm_checker (.*);

### test/pixel_kspace_mapper_top_tb.sv
// Self-checking testbench for pixel_kspace_mapper_top: directed pixels, then random ones.
module pixel_kspace_mapper_top_tb;

  localparam logic [pkm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES = 8;
  localparam int RAND_PER_PHASE = 155;
  localparam longint Z_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint Z_BOT = 64'sh8000_0000_0000_0000;
  localparam logic [31:0] D_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [23:0]        rad;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] kx;
    logic signed [31:0] ky;
    logic signed [31:0] kz;
    logic [31:0]        kmag;
    logic [31:0]        d;
    logic               sat;
    logic               mask;
    logic               last;
  } kvec_t;

  typedef struct packed {
    pixel_t px;
    logic   typed;
    kvec_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [23:0] radius_px = '0;
  logic last_pixel = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  logic signed [31:0] k_x, k_y, k_z;
  logic [31:0] k_mag, d_spacing;
  logic saturated, in_mask, last_out;

  pkm_pkg::cfg_t regs = pkm_pkg::CFG_RESET;
  kvec_t pending_k[$];
  int errors = 0;
  bit idle_on = 1'b1;
  row_t rows[12];

  pixel_kspace_mapper_top uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint pos_to_nm(input logic signed [23:0] pos, input logic [19:0] pitch);
    longint p, m;
    p = longint'(pos) * longint'(pitch);
    m = ((p < 0 ? -p : p) + 128) >>> 8;
    return p < 0 ? -m : m;
  endfunction

  function automatic logic [31:0] clip_s(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin sat = 1'b1; return 32'h7FFF_FFFF; end
    if (v < -64'sd2147483648) begin sat = 1'b1; return 32'h8000_0000; end
    return v[31:0];
  endfunction

  function automatic logic [31:0] clip_u(input longint unsigned v, inout logic sat);
    if (v > 64'hFFFF_FFFF) begin sat = 1'b1; return 32'hFFFF_FFFF; end
    return v[31:0];
  endfunction

  function automatic kvec_t map_pixel(input pixel_t p, input pkm_pkg::cfg_t c);
    kvec_t o;
    longint unsigned w, ax, ay, az, m, r, rho, kxm, kym, kzm, root;
    longint xn, yn, zp, zs, zn, qx, qy, qz;
    int s;
    o = '0;
    w = (c.wavelength == 0) ? 1 : c.wavelength;
    xn = pos_to_nm(p.x, c.pitch);
    yn = pos_to_nm(p.y, c.pitch);
    zp = pos_to_nm(p.z, c.pitch);
    zs = longint'(c.stage_pos) * longint'(c.stage_scale);
    if (zp > 0 && zs > Z_TOP - zp) begin zn = Z_TOP; o.sat = 1'b1; end
    else if (zp < 0 && zs < Z_BOT - zp) begin zn = Z_BOT; o.sat = 1'b1; end
    else zn = zs + zp;
    ax = xn < 0 ? -xn : xn;
    ay = yn < 0 ? -yn : yn;
    az = zn < 0 ? -zn : zn;
    m = ax > ay ? ax : ay;
    if (az > m) m = az;
    s = 0;
    while ((m >> s) >= 64'd1 << 30) s++;
    ax >>= s; ay >>= s; az >>= s;
    r = isqrt(ax * ax + ay * ay + az * az);
    rho = isqrt(ax * ax + ay * ay);
    if (r == 0) begin
      o.d = D_SAT;
      o.sat = 1'b1;
    end else begin
      qx = (ax << 30) / r;
      qy = (ay << 30) / r;
      qz = (az << 30) / r;
      if (zn < 0) qz = -qz;
      kxm = qx;
      kym = qy;
      kzm = (64'sd1 <<< 30) - qz;
      root = isqrt(kxm * kxm + kym * kym + kzm * kzm);
      qx = (kxm << 10) / w;
      qy = (kym << 10) / w;
      o.kx = clip_s(xn < 0 ? -qx : qx, o.sat);
      o.ky = clip_s(yn < 0 ? -qy : qy, o.sat);
      o.kz = clip_s(-longint'((kzm << 10) / w), o.sat);
      o.kmag = clip_u((root << 10) / w, o.sat);
      if (rho == 0) begin
        o.d = D_SAT;
        o.sat = 1'b1;
      end else begin
        o.d = clip_u((w * r) / rho, o.sat);
      end
    end
    o.mask = (p.rad > c.mask_inner) && (p.rad < c.mask_outer);
    o.last = p.last;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act);
    if (exp_v !== act) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    kvec_t e;
    if (!rst && done) begin
      if (pending_k.size() == 0) begin
        $error("unexpected result strobe");
        errors++;
      end else begin
        e = pending_k.pop_front();
        check_field("k_x", e.kx, k_x);
        check_field("k_y", e.ky, k_y);
        check_field("k_z", e.kz, k_z);
        check_field("k_mag", e.kmag, k_mag);
        check_field("d_spacing", e.d, d_spacing);
        check_field("saturated", 32'(e.sat), 32'(saturated));
        check_field("in_mask", 32'(e.mask), 32'(in_mask));
        check_field("last_out", 32'(e.last), 32'(last_out));
      end
    end
  end

  // issue one request; start stays high across back-to-back requests
  task automatic send_pixel(input pixel_t p, input logic typed, input kvec_t res);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk);
    end
    pos_x = p.x; pos_y = p.y; pos_z = p.z;
    radius_px = p.rad; last_pixel = p.last;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_k.push_back(typed ? res : map_pixel(p, regs));
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_k.size() != 0) @(negedge clk);
    repeat (pkm_pkg::LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
  endtask

  task automatic load_cfg(input pkm_pkg::cfg_t c);
    drain();
    write_reg(pkm_pkg::REG_PITCH, 32'(c.pitch));
    write_reg(pkm_pkg::REG_STAGE_POS, c.stage_pos);
    write_reg(pkm_pkg::REG_STAGE_SCALE, c.stage_scale);
    write_reg(pkm_pkg::REG_WAVELENGTH, 32'(c.wavelength));
    write_reg(pkm_pkg::REG_MASK_OUTER, 32'(c.mask_outer));
    write_reg(pkm_pkg::REG_MASK_INNER, 32'(c.mask_inner));
    // out-of-range index must be dropped
    write_reg(REG_UNUSED, $urandom);
    cfg_we = 1'b0;
    regs = c;
  endtask

  function automatic logic signed [23:0] rand_pos();
    case ($urandom_range(0, 4))
      0, 1: return 24'($urandom);
      2: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
      3: case ($urandom_range(0, 3))
           0: return 24'sh7F_FFFF;
           1: return 24'sh80_0000;
           2: return -24'sd1;
           default: return 24'sd1;
         endcase
      default: return '0;
    endcase
  endfunction

  function automatic pkm_pkg::cfg_t rand_cfg();
    pkm_pkg::cfg_t c;
    c.pitch = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(1, 200000));
    c.stage_pos = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 2000)) - 1000;
    c.stage_scale = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 2000000);
    c.wavelength = $urandom_range(0, 2) == 0 ? 24'($urandom) : 24'($urandom_range(0, 200000));
    c.mask_outer = 24'($urandom);
    c.mask_inner = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 4096));
    return c;
  endfunction

  initial begin
    pixel_t p;
    pkm_pkg::cfg_t c;
    rows[0]  = '{px: '{0, 0, 0, 24'd0, 1'b1}, typed: 1'b1,
                 res: '{0, 0, 0, 0, D_SAT, 1'b1, 1'b0, 1'b1}};
    rows[1]  = '{px: '{0, 0, 24'sd100, 24'd5, 1'b0}, typed: 1'b1,
                 res: '{0, 0, 0, 0, D_SAT, 1'b1, 1'b1, 1'b0}};
    rows[2]  = '{px: '{0, 0, 0, 24'hFF_FFFF, 1'b0}, typed: 1'b1,
                 res: '{0, 0, 0, 0, D_SAT, 1'b1, 1'b0, 1'b0}};
    rows[3]  = '{px: '{0, 0, -24'sd100, 24'd1, 1'b1}, typed: 1'b1,
                 res: '{0, 0, -32'sd33554432, 32'd33554432, D_SAT, 1'b1, 1'b1, 1'b1}};
    rows[4]  = '{px: '{24'sh7F_FFFF, 0, 0, 24'hFF_FFFE, 1'b0}, typed: 1'b0, res: '0};
    rows[5]  = '{px: '{24'sh80_0000, 0, 0, 24'd1, 1'b0}, typed: 1'b0, res: '0};
    rows[6]  = '{px: '{0, 24'sh7F_FFFF, 24'sh80_0000, 24'd100, 1'b0}, typed: 1'b0, res: '0};
    rows[7]  = '{px: '{24'sh80_0000, 24'sh80_0000, 24'sh80_0000, 24'd0, 1'b1}, typed: 1'b0,
                 res: '0};
    rows[8]  = '{px: '{24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF, 24'h80_0000, 1'b0}, typed: 1'b0,
                 res: '0};
    rows[9]  = '{px: '{24'sd1, -24'sd1, 24'sd1, 24'h55_5555, 1'b1}, typed: 1'b0, res: '0};
    rows[10] = '{px: '{-24'sd300, 24'sd700, 24'sd2000, 24'hAA_AAAA, 1'b0}, typed: 1'b0, res: '0};
    rows[11] = '{px: '{24'sd256, 24'sd256, -24'sd256, 24'd256, 1'b1}, typed: 1'b0, res: '0};

    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: c = pkm_pkg::CFG_RESET;
        1: c = '{20'd1, 32'sd0, 32'd0, 24'd1, 24'd1000, 24'd10};
        2: c = '{20'hF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF};
        3: c = '{20'd0, 32'sh8000_0000, 32'hFFFF_FFFF, 24'd0, 24'd50, 24'd50};
        default: c = rand_cfg();
      endcase
      load_cfg(c);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 40 == 0) idle_on = $urandom_range(0, 2) != 0;
        p.x = rand_pos();
        p.y = rand_pos();
        p.z = rand_pos();
        p.rad = $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 2000)) : 24'($urandom);
        p.last = 1'($urandom);
        send_pixel(p, 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending_k.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
